### hdl/stereo_resonant_two_pole_lowpass_unit_macros.svh
// Assertion macros for the stereo resonant two-pole low-pass unit.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef STEREO_RESONANT_TWO_POLE_LOWPASS_UNIT_MACROS_SVH
`define STEREO_RESONANT_TWO_POLE_LOWPASS_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SRTPL_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("assertion failed: forbidden condition seen");
`define SRTPL_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");
`else
`define SRTPL_ASSERT_NEVER(label, clk, rstn, cond)
`define SRTPL_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`endif
`endif

### hdl/srtpl_pkg.sv
// Shared types, constants and arithmetic helpers of the two-pole low-pass unit.
// Depends on nothing.
package srtpl_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int CHANNEL_COUNT = 2;
    localparam int STATE_BITS    = SAMPLE_BITS + 4;
    localparam int COEF_BITS     = 17;
    localparam int ACC_BITS      = STATE_BITS + COEF_BITS + 3;
    localparam int RND_BITS      = ACC_BITS - 16;
    localparam int CNT_BITS      = $clog2(COEF_BITS + 1);
    localparam int ADDR_BITS     = 4;

    localparam logic [COEF_BITS-1:0] COEF_ONE       = COEF_BITS'(65536);
    localparam logic [COEF_BITS-1:0] CUTOFF_RESET   = COEF_BITS'(4096);
    localparam logic [COEF_BITS-1:0] RESONANCE_RESET = COEF_BITS'(23170);
    localparam logic [1:0]           ACTIVE_RESET   = 2'd2;

    localparam logic [1:0] REG_CUTOFF    = 2'd0;
    localparam logic [1:0] REG_RESONANCE = 2'd1;
    localparam logic [1:0] REG_ACTIVE    = 2'd2;

    typedef struct packed {
        logic                          channel;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          block_last;
    } in_item_t;

    typedef struct packed {
        logic                          channel_out;
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          block_last_out;
    } out_item_t;

    typedef struct packed {
        logic [COEF_BITS-1:0] cutoff;
        logic [COEF_BITS-1:0] resonance;
        logic [1:0]           active;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic negate;
    } mac_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_WAIT,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        STEP_RC,
        STEP_D_V0,
        STEP_C_X,
        STEP_C_V1,
        STEP_D_V1,
        STEP_C_V0
    } step_t;

    // Round half up, drop 16 fraction bits.
    function automatic logic signed [RND_BITS-1:0] round_q16(
        input logic signed [ACC_BITS-1:0] acc);
        logic signed [ACC_BITS-1:0] sum;
        begin
            sum = acc + ACC_BITS'(32768);
            round_q16 = sum[ACC_BITS-1:16];
        end
    endfunction

    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [RND_BITS-1:0] v);
        logic signed [RND_BITS-1:0] hi;
        logic signed [RND_BITS-1:0] lo;
        begin
            hi = RND_BITS'((64'sd1 <<< (STATE_BITS - 1)) - 64'sd1);
            lo = -hi - RND_BITS'(1);
            if (v > hi) begin
                sat_state = hi[STATE_BITS-1:0];
            end else if (v < lo) begin
                sat_state = lo[STATE_BITS-1:0];
            end else begin
                sat_state = v[STATE_BITS-1:0];
            end
        end
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [STATE_BITS-1:0] v);
        logic signed [STATE_BITS-1:0] hi;
        logic signed [STATE_BITS-1:0] lo;
        begin
            hi = STATE_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
            lo = -hi - STATE_BITS'(1);
            if (v > hi) begin
                sat_sample = hi[SAMPLE_BITS-1:0];
            end else if (v < lo) begin
                sat_sample = lo[SAMPLE_BITS-1:0];
            end else begin
                sat_sample = v[SAMPLE_BITS-1:0];
            end
        end
    endfunction

    function automatic logic [COEF_BITS-1:0] clamp_coef(input logic [31:0] value);
        logic [COEF_BITS-1:0] v;
        begin
            v = value[COEF_BITS-1:0];
            clamp_coef = (v > COEF_ONE) ? COEF_ONE : v;
        end
    endfunction

endpackage

### hdl/srtpl_regs.sv
// APB-style configuration registers of the two-pole low-pass unit.
// Depends on srtpl_pkg.
module srtpl_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [srtpl_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output srtpl_pkg::cfg_t                   cfg
);

    srtpl_pkg::cfg_t cfg_reg;
    srtpl_pkg::cfg_t cfg_next;
    logic [1:0]      index;
    logic            wr_en;

    assign index  = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (index)
                srtpl_pkg::REG_CUTOFF:    cfg_next.cutoff = srtpl_pkg::clamp_coef(pwdata);
                srtpl_pkg::REG_RESONANCE: cfg_next.resonance = srtpl_pkg::clamp_coef(pwdata);
                srtpl_pkg::REG_ACTIVE:    cfg_next.active = pwdata[1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (index)
            srtpl_pkg::REG_CUTOFF:    prdata = 32'(cfg_reg.cutoff);
            srtpl_pkg::REG_RESONANCE: prdata = 32'(cfg_reg.resonance);
            srtpl_pkg::REG_ACTIVE:    prdata = 32'(cfg_reg.active);
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cutoff    <= srtpl_pkg::CUTOFF_RESET;
            cfg_reg.resonance <= srtpl_pkg::RESONANCE_RESET;
            cfg_reg.active    <= srtpl_pkg::ACTIVE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/srtpl_mac.sv
// Bit-serial multiply-accumulate: one coefficient bit per cycle.
// Depends on srtpl_pkg.
module srtpl_mac (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  srtpl_pkg::mac_op_t                        op,
    input  logic signed [srtpl_pkg::STATE_BITS-1:0]   mcand,
    input  logic [srtpl_pkg::COEF_BITS-1:0]           mplier,
    output logic signed [srtpl_pkg::ACC_BITS-1:0]     acc,
    output logic                                      busy,
    output logic                                      done
);

    logic signed [srtpl_pkg::ACC_BITS-1:0] acc_reg, acc_next;
    logic signed [srtpl_pkg::ACC_BITS-1:0] mcand_reg, mcand_next;
    logic [srtpl_pkg::COEF_BITS-1:0]       mplier_reg, mplier_next;
    logic [srtpl_pkg::CNT_BITS-1:0]        cnt_reg, cnt_next;
    logic                                  busy_reg, busy_next;
    logic                                  done_reg, done_next;
    logic signed [srtpl_pkg::ACC_BITS-1:0] ext;

    assign ext  = srtpl_pkg::ACC_BITS'(mcand);
    assign acc  = acc_reg;
    assign busy = busy_reg;
    assign done = done_reg;

    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (op.start && !busy_reg) begin
            acc_next    = op.clear ? '0 : acc_reg;
            mcand_next  = op.negate ? -ext : ext;
            mplier_next = mplier;
            cnt_next    = srtpl_pkg::CNT_BITS'(srtpl_pkg::COEF_BITS);
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            // add the shifted multiplicand where the current bit is set
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - srtpl_pkg::CNT_BITS'(1);
            if (cnt_reg == srtpl_pkg::CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

endmodule

### hdl/stereo_resonant_two_pole_lowpass_unit.sv
// Top level of the stereo resonant two-pole low-pass unit.
// Depends on srtpl_pkg, srtpl_regs, srtpl_mac and the assertion macro header.
//
// One item carries a signed Q1.23 sample and its channel. For a filtered
// channel the unit runs six products through one bit-serial multiplier that
// retires one coefficient bit per cycle: r*c, then d*v0 + c*x - c*v1, then
// d*v1 + c*v0. Each product is launched, then the multiplier steps through
// the coefficient bits and hands back the sum; after the last product the
// result is saturated and offered, and no new item is accepted until it has
// gone to the output register. An item on an inactive channel skips the
// arithmetic: it passes through the done state to the output register
// without touching state.
// One item is in work at a time; the result sits in an output register so
// the next item may be accepted while it waits. Coefficients are written
// over the APB-style port (cutoff at 0x0, resonance at 0x4, active channel
// count at 0x8) and must only change while the unit is idle.
`include "stereo_resonant_two_pole_lowpass_unit_macros.svh"
module stereo_resonant_two_pole_lowpass_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [srtpl_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  srtpl_pkg::in_item_t               s_payload,
    output logic                              m_valid,
    input  logic                              m_ready,
    output srtpl_pkg::out_item_t              m_payload
);

    localparam int SB = srtpl_pkg::SAMPLE_BITS;
    localparam int TB = srtpl_pkg::STATE_BITS;
    localparam int CB = srtpl_pkg::COEF_BITS;

    srtpl_pkg::cfg_t cfg;

    srtpl_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srtpl_pkg::state_t state_reg, state_next;
    srtpl_pkg::step_t  step_reg, step_next;

    logic                 ch_reg, ch_next;
    logic signed [SB-1:0] x_reg, x_next;
    logic                 last_reg, last_next;
    logic signed [SB-1:0] res_reg, res_next;
    logic [CB-1:0]        d_reg, d_next;

    // integrator state, one entry per channel
    logic signed [TB-1:0] v0_reg [srtpl_pkg::CHANNEL_COUNT];
    logic signed [TB-1:0] v1_reg [srtpl_pkg::CHANNEL_COUNT];
    logic                 v0_wr, v1_wr;
    logic signed [TB-1:0] v_new;

    logic                 m_valid_reg, m_valid_next;
    srtpl_pkg::out_item_t m_payload_reg, m_payload_next;

    srtpl_pkg::mac_op_t                     mac_op;
    logic signed [TB-1:0]                   mac_a;
    logic [CB-1:0]                          mac_b;
    logic signed [srtpl_pkg::ACC_BITS-1:0]  mac_acc;
    logic                                   mac_busy;
    logic                                   mac_done;
    logic signed [srtpl_pkg::RND_BITS-1:0]  rounded;
    logic                                   filtered;
    logic                                   ch_idx;

    srtpl_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (mac_op),
        .mcand   (mac_a),
        .mplier  (mac_b),
        .acc     (mac_acc),
        .busy    (mac_busy),
        .done    (mac_done)
    );

    assign s_ready   = (state_reg == srtpl_pkg::S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;
    assign rounded   = srtpl_pkg::round_q16(mac_acc);
    assign v_new     = srtpl_pkg::sat_state(rounded);
    assign ch_idx    = ch_reg;

    // a channel is filtered below both the active count and the channel count
    assign filtered = ({1'b0, s_payload.channel} < cfg.active) &&
                      (32'(s_payload.channel) < srtpl_pkg::CHANNEL_COUNT);

    // operand select for each product of the sequence
    always_comb begin
        mac_a         = v0_reg[ch_idx];
        mac_b         = cfg.cutoff;
        mac_op.start  = (state_reg == srtpl_pkg::S_LAUNCH);
        mac_op.clear  = 1'b0;
        mac_op.negate = 1'b0;
        case (step_reg)
            srtpl_pkg::STEP_RC: begin
                mac_a        = TB'(cfg.resonance);
                mac_op.clear = 1'b1;
            end
            srtpl_pkg::STEP_D_V0: begin
                mac_a        = v0_reg[ch_idx];
                mac_b        = d_reg;
                mac_op.clear = 1'b1;
            end
            srtpl_pkg::STEP_C_X: mac_a = TB'(x_reg);
            srtpl_pkg::STEP_C_V1: begin
                mac_a         = v1_reg[ch_idx];
                mac_op.negate = 1'b1;
            end
            srtpl_pkg::STEP_D_V1: begin
                mac_a        = v1_reg[ch_idx];
                mac_b        = d_reg;
                mac_op.clear = 1'b1;
            end
            srtpl_pkg::STEP_C_V0: mac_a = v0_reg[ch_idx];
            default: mac_a = v0_reg[ch_idx];
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        ch_next        = ch_reg;
        x_next         = x_reg;
        last_next      = last_reg;
        res_next       = res_reg;
        d_next         = d_reg;
        v0_wr          = 1'b0;
        v1_wr          = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        case (state_reg)
            srtpl_pkg::S_IDLE: begin
                if (s_valid) begin
                    ch_next   = s_payload.channel;
                    x_next    = s_payload.sample_in;
                    last_next = s_payload.block_last;
                    res_next  = s_payload.sample_in;
                    step_next = srtpl_pkg::STEP_RC;
                    // inactive channel: skip the arithmetic entirely
                    state_next = filtered ? srtpl_pkg::S_LAUNCH : srtpl_pkg::S_DONE;
                end
            end
            srtpl_pkg::S_LAUNCH: begin
                state_next = srtpl_pkg::S_WAIT;
            end
            srtpl_pkg::S_WAIT: begin
                if (mac_done) begin
                    state_next = srtpl_pkg::S_LAUNCH;
                    case (step_reg)
                        srtpl_pkg::STEP_RC: begin
                            d_next    = srtpl_pkg::COEF_ONE - CB'(rounded);
                            step_next = srtpl_pkg::STEP_D_V0;
                        end
                        srtpl_pkg::STEP_D_V0: step_next = srtpl_pkg::STEP_C_X;
                        srtpl_pkg::STEP_C_X:  step_next = srtpl_pkg::STEP_C_V1;
                        srtpl_pkg::STEP_C_V1: begin
                            v0_wr     = 1'b1;
                            step_next = srtpl_pkg::STEP_D_V1;
                        end
                        srtpl_pkg::STEP_D_V1: step_next = srtpl_pkg::STEP_C_V0;
                        srtpl_pkg::STEP_C_V0: begin
                            v1_wr      = 1'b1;
                            res_next   = srtpl_pkg::sat_sample(v_new);
                            state_next = srtpl_pkg::S_DONE;
                        end
                        default: state_next = srtpl_pkg::S_IDLE;
                    endcase
                end
            end
            srtpl_pkg::S_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                  = 1'b1;
                    m_payload_next.channel_out    = ch_reg;
                    m_payload_next.sample_out     = res_reg;
                    m_payload_next.block_last_out = last_reg;
                    state_next                    = srtpl_pkg::S_IDLE;
                end
            end
            default: state_next = srtpl_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= srtpl_pkg::S_IDLE;
            step_reg    <= srtpl_pkg::STEP_RC;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < srtpl_pkg::CHANNEL_COUNT; i++) begin
                v0_reg[i] <= '0;
                v1_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            if (v0_wr) begin
                v0_reg[ch_idx] <= v_new;
            end
            if (v1_wr) begin
                v1_reg[ch_idx] <= v_new;
            end
        end
        ch_reg        <= ch_next;
        x_reg         <= x_next;
        last_reg      <= last_next;
        res_reg       <= res_next;
        d_reg         <= d_next;
        m_payload_reg <= m_payload_next;
    end

    // accept an item only while the multiplier is quiet
    `SRTPL_ASSERT_IMPLIES(a_accept_mac_idle, aclk, aresetn, s_valid && s_ready, !mac_busy)
    // a finished product is only ever seen while waiting for it
    `SRTPL_ASSERT_NEVER(a_done_in_wait, aclk, aresetn, mac_done && (state_reg != srtpl_pkg::S_WAIT))
    // state is written only by a finished product
    `SRTPL_ASSERT_IMPLIES(a_state_write, aclk, aresetn, v0_wr || v1_wr, mac_done)

endmodule

### tb/stereo_resonant_two_pole_lowpass_unit_test.sv
// Testbench for the stereo resonant two-pole low-pass unit: drives items and
// register writes, predicts every result and checks it field by field.
// Depends on srtpl_pkg and the unit's top level.
`timescale 1ns / 100ps
module stereo_resonant_two_pole_lowpass_unit_test;

    logic aclk;
    logic aresetn;
    logic psel, penable, pwrite;
    logic [srtpl_pkg::ADDR_BITS-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic s_valid, s_ready;
    srtpl_pkg::in_item_t s_payload;
    logic m_valid, m_ready;
    srtpl_pkg::out_item_t m_payload;

    stereo_resonant_two_pole_lowpass_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Predictor copy of the configuration and integrators.
    logic [16:0] cut_q, res_q;
    logic [1:0]  act_q;
    longint      integ1 [2] = '{0, 0};
    longint      integ2 [2] = '{0, 0};

    srtpl_pkg::in_item_t  pending_items [$];
    srtpl_pkg::out_item_t expected_samples [$];
    int        fail_count = 0;
    longint    cycle_count = 0;
    int        sent_count = 0;
    int        got_count = 0;
    bit        hold_rx;        // long receiver hold-off request
    bit        hold_taken;
    int        hold_left;

    function automatic longint clamp_to(input longint v, input int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // Round half up and drop 16 fraction bits; arithmetic shift floors.
    function automatic longint round_drop16(input longint s);
        return (s + 32768) >>> 16;
    endfunction

    function automatic srtpl_pkg::out_item_t filter_sample(input srtpl_pkg::in_item_t it);
        srtpl_pkg::out_item_t o;
        longint c, r, rc, d, x, v0, v1;
        o.channel_out    = it.channel;
        o.block_last_out = it.block_last;
        o.sample_out     = it.sample_in;
        if (it.channel < act_q) begin
            c  = cut_q;
            r  = res_q;
            rc = (r * c + 32768) >>> 16;
            d  = 65536 - rc;
            x  = it.sample_in;
            v0 = integ1[it.channel];
            v1 = integ2[it.channel];
            v0 = clamp_to(round_drop16(d * v0 - c * v1 + c * x), srtpl_pkg::STATE_BITS);
            v1 = clamp_to(round_drop16(d * v1 + c * v0), srtpl_pkg::STATE_BITS);
            integ1[it.channel] = v0;
            integ2[it.channel] = v1;
            o.sample_out = srtpl_pkg::SAMPLE_BITS'(clamp_to(v1, srtpl_pkg::SAMPLE_BITS));
        end
        return o;
    endfunction

    // Driver: offer queued items, random gap after each.
    int tx_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_payload <= '0;
            tx_gap    <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_samples.push_back(filter_sample(s_payload));
                sent_count++;
            end
            if (s_valid && !s_ready) begin
                // hold the item
            end else if (tx_gap > 0) begin
                s_valid <= 1'b0;
                tx_gap  <= tx_gap - 1;
            end else if (pending_items.size() > 0) begin
                s_payload <= pending_items.pop_front();
                s_valid   <= 1'b1;
                tx_gap    <= $urandom_range(0, 7);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: check results, random stalls and one long hold-off.
    int rx_gap;
    always @(posedge aclk) begin
        srtpl_pkg::out_item_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            rx_gap     <= 0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got_count++;
                if (expected_samples.size() == 0) begin
                    $error("result with no expectation: %h", m_payload);
                    fail_count++;
                end else begin
                    want = expected_samples.pop_front();
                    if (m_payload.channel_out !== want.channel_out) begin
                        $error("channel_out exp %0d got %0d",
                               want.channel_out, m_payload.channel_out);
                        fail_count++;
                    end
                    if (m_payload.sample_out !== want.sample_out) begin
                        $error("sample_out exp %0d got %0d",
                               want.sample_out, m_payload.sample_out);
                        fail_count++;
                    end
                    if (m_payload.block_last_out !== want.block_last_out) begin
                        $error("block_last_out exp %0d got %0d",
                               want.block_last_out, m_payload.block_last_out);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (hold_rx && !hold_taken) begin
                hold_taken <= 1'b1;
                hold_left  <= 3000;
                m_ready    <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap  <= rx_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (m_valid && m_ready) rx_gap <= $urandom_range(0, 7);
            end
        end
    end

    // Timeout: bounds the slowest run of about 950 items plus holds.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 2000000) begin
            $display("stereo_resonant_two_pole_lowpass_unit_test failed");
            $finish;
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= srtpl_pkg::ADDR_BITS'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // mirror the register write in the predictor
        if (idx == srtpl_pkg::REG_CUTOFF) cut_q = srtpl_pkg::clamp_coef(value);
        else if (idx == srtpl_pkg::REG_RESONANCE) res_q = srtpl_pkg::clamp_coef(value);
        else if (idx == srtpl_pkg::REG_ACTIVE) act_q = value[1:0];
    endtask

    // Wait until the unit has drained, then let in-flight work settle.
    task automatic drain;
        while (pending_items.size() > 0 || s_valid || expected_samples.size() > 0)
            @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    function automatic srtpl_pkg::in_item_t make_item(input logic ch,
                                                      input logic [23:0] smp,
                                                      input logic last);
        srtpl_pkg::in_item_t it;
        it.channel    = ch;
        it.sample_in  = smp;
        it.block_last = last;
        return it;
    endfunction

    // Mostly full-scale extremes or quiet values, some full-scale noise.
    function automatic logic [23:0] rand_sample();
        int k;
        k = $urandom_range(0, 9);
        if (k < 2) return 24'h7FFFFF;
        if (k < 4) return 24'h800000;
        if (k < 7) return 24'($signed($urandom_range(0, 65535)) - 32768);
        return 24'($urandom);
    endfunction

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            pending_items.push_back(make_item(1'($urandom_range(0, 1)), rand_sample(),
                                              1'($urandom_range(0, 1))));
    endtask

    initial begin
        logic [31:0] cut_set [5];
        logic [31:0] res_set [5];
        hold_rx = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        cut_q = 17'd4096; res_q = 17'd23170; act_q = 2'd2;
        aresetn = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes on both channels at reset coefficients.
        pending_items.push_back(make_item(1'b0, 24'h7FFFFF, 1'b0));
        pending_items.push_back(make_item(1'b1, 24'h800000, 1'b1));
        pending_items.push_back(make_item(1'b0, 24'h000000, 1'b0));
        pending_items.push_back(make_item(1'b1, 24'h000001, 1'b0));
        pending_items.push_back(make_item(1'b0, 24'hFFFFFF, 1'b1));
        pending_items.push_back(make_item(1'b1, 24'h555555, 1'b0));
        pending_items.push_back(make_item(1'b0, 24'hAAAAAA, 1'b1));
        drain();
        // Coefficient above one saturates; full cutoff, zero damping.
        apb_write(srtpl_pkg::REG_CUTOFF, 32'h1FFFF);
        apb_write(srtpl_pkg::REG_RESONANCE, 32'd0);
        for (int i = 0; i < 6; i++)
            pending_items.push_back(make_item(i[0], i[1] ? 24'h7FFFFF : 24'h800000,
                                              i[2]));
        drain();
        // Active count of zero, one and three; both channels each.
        apb_write(srtpl_pkg::REG_ACTIVE, 32'd0);
        pending_items.push_back(make_item(1'b0, 24'h123456, 1'b1));
        pending_items.push_back(make_item(1'b1, 24'h800000, 1'b0));
        drain();
        apb_write(srtpl_pkg::REG_ACTIVE, 32'd1);
        pending_items.push_back(make_item(1'b0, 24'h7FFFFF, 1'b0));
        pending_items.push_back(make_item(1'b1, 24'h7FFFFF, 1'b1));
        drain();
        apb_write(srtpl_pkg::REG_ACTIVE, 32'd3);
        apb_write(srtpl_pkg::REG_RESONANCE, 32'd65536);
        pending_items.push_back(make_item(1'b0, 24'h800000, 1'b0));
        pending_items.push_back(make_item(1'b1, 24'h7FFFFF, 1'b1));
        drain();
        // Unknown register index is ignored.
        apb_write(2'd3, 32'hFFFFFFFF);

        // Random phases over several coefficient settings.
        cut_set = '{32'd0, 32'd65536, 32'd4096, 32'd300, 32'd40000};
        res_set = '{32'd65536, 32'd0, 32'd23170, 32'd1000, 32'd90000};
        for (int p = 0; p < 5; p++) begin
            apb_write(srtpl_pkg::REG_CUTOFF, p == 4 ? $urandom : cut_set[p]);
            apb_write(srtpl_pkg::REG_RESONANCE, res_set[p]);
            apb_write(srtpl_pkg::REG_ACTIVE, $urandom_range(0, 3));
            if (p == 2) hold_rx = 1'b1;  // receiver stalls while sender offers
            queue_random(185);
            drain();
        end

        $display("ran %0d items, %0d results, over directed extremes and five random phases",
                 sent_count, got_count);
        if (fail_count == 0 && expected_samples.size() == 0) begin
            $display("stereo_resonant_two_pole_lowpass_unit_test passed");
        end else begin
            $display("stereo_resonant_two_pole_lowpass_unit_test failed");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+hdl
hdl/srtpl_pkg.sv
hdl/srtpl_regs.sv
hdl/srtpl_mac.sv
hdl/stereo_resonant_two_pole_lowpass_unit.sv
tb/stereo_resonant_two_pole_lowpass_unit_test.sv
